[design/symi_pkg.sv]
// Shared widths, index constants and request types for the symmetric 3x3 inverse.
// Used by symi_front, symi_div_lane and symm3x3_inverse; depends on nothing.
package symi_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int NUM_ELEM = 6;

  // Voigt order of the six entries
  localparam int IDX_XX = 0;
  localparam int IDX_YY = 1;
  localparam int IDX_ZZ = 2;
  localparam int IDX_YZ = 3;
  localparam int IDX_XZ = 4;
  localparam int IDX_XY = 5;

  localparam int PROD_W = 2 * DATA_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int PART_W = 2 * DATA_W + 1;
  localparam int DET_W  = 3 * DATA_W + 3;
  localparam int SHIFT_W = COF_W + 2 * FRAC_W + 1;
  localparam int NUM_W  = ((SHIFT_W > DET_W) ? SHIFT_W : DET_W) + 1;
  localparam int QUO_W  = DATA_W;
  localparam int CMP_W  = NUM_W + QUO_W;

  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

  localparam int TDATA_W = ((NUM_ELEM * DATA_W + 7) / 8) * 8;
  localparam int TUSER_W = 2;
  localparam int USER_SINGULAR = 0;
  localparam int USER_OVERFLOW = 1;

  localparam logic [QUO_W-1:0] LIM_POS = {1'b0, {(QUO_W-1){1'b1}}};
  localparam logic [QUO_W-1:0] LIM_NEG = {1'b1, {(QUO_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } lane_t;

  typedef struct packed {
    logic                   sing;
    lane_t [NUM_ELEM-1:0]   lane;
  } front_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

[design/symi_front.sv]
// Front end: cofactors, exact determinant, magnitudes and division operands.
// Six register stages; depends on symi_pkg.
module symi_front (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  symi_pkg::elem_t [symi_pkg::NUM_ELEM-1:0] elem_i,
  output symi_pkg::front_t              front_o
);
  import symi_pkg::*;

  logic signed [PROD_W-1:0] pa_q [NUM_ELEM];
  logic signed [PROD_W-1:0] pb_q [NUM_ELEM];
  elem_t                    ex1_q [3];
  logic signed [COF_W-1:0]  cof2_q [NUM_ELEM];
  elem_t                    ex2_q [3];
  logic signed [PART_W-1:0] lo_q [3];
  logic signed [PART_W-1:0] hi_q [3];
  logic signed [COF_W-1:0]  cof3_q [NUM_ELEM];
  logic signed [DET_W-1:0]  term_q [3];
  logic signed [COF_W-1:0]  cof4_q [NUM_ELEM];
  logic signed [DET_W-1:0]  det_q;
  logic signed [COF_W-1:0]  cof5_q [NUM_ELEM];
  front_t                   front_q;

  logic signed [COF_W-1:0]  det_cof [3];
  logic signed [PART_W-1:0] lo_d [3];
  logic signed [PART_W-1:0] hi_d [3];
  logic signed [DATA_W:0]   cof_lo [3];
  logic signed [DATA_W:0]   cof_hi [3];
  logic                     det_neg;
  logic [DET_W-1:0]         det_abs;
  front_t                   front_d;

  elem_t xx, yy, zz, yz, xz, xy;
  assign xx = elem_i[IDX_XX];
  assign yy = elem_i[IDX_YY];
  assign zz = elem_i[IDX_ZZ];
  assign yz = elem_i[IDX_YZ];
  assign xz = elem_i[IDX_XZ];
  assign xy = elem_i[IDX_XY];

  // Stage 1: the twelve cofactor products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q[IDX_XX] <= yy * zz;  pb_q[IDX_XX] <= yz * yz;
      pa_q[IDX_YY] <= xx * zz;  pb_q[IDX_YY] <= xz * xz;
      pa_q[IDX_ZZ] <= xx * yy;  pb_q[IDX_ZZ] <= xy * xy;
      pa_q[IDX_YZ] <= xz * xy;  pb_q[IDX_YZ] <= xx * yz;
      pa_q[IDX_XZ] <= xy * yz;  pb_q[IDX_XZ] <= xz * yy;
      pa_q[IDX_XY] <= xz * yz;  pb_q[IDX_XY] <= xy * zz;
      ex1_q[0] <= xx;
      ex1_q[1] <= xy;
      ex1_q[2] <= xz;
    end
  end

  // Stage 2: cofactor differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        cof2_q[i] <= COF_W'(pa_q[i]) - COF_W'(pb_q[i]);
      end
      ex2_q <= ex1_q;
    end
  end

  // Stage 3: det = xx*c_xx + xy*c_xy + xz*c_xz, each cofactor split in two halves
  assign det_cof[0] = cof2_q[IDX_XX];
  assign det_cof[1] = cof2_q[IDX_XY];
  assign det_cof[2] = cof2_q[IDX_XZ];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cof_lo[j] = $signed({1'b0, det_cof[j][DATA_W-1:0]});
      cof_hi[j] = det_cof[j][COF_W-1:DATA_W];
      lo_d[j]   = ex2_q[j] * cof_lo[j];
      hi_d[j]   = ex2_q[j] * cof_hi[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      cof3_q <= cof2_q;
    end
  end

  // Stage 4: recombine the halves of each term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        term_q[j] <= DET_W'(lo_q[j]) + (DET_W'(hi_q[j]) <<< DATA_W);
      end
      cof4_q <= cof3_q;
    end
  end

  // Stage 5: determinant sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      cof5_q <= cof4_q;
    end
  end

  // Stage 6: magnitudes; numerator carries the half-divisor for rounding
  assign det_neg = det_q[DET_W-1];
  assign det_abs = det_neg ? DET_W'(-det_q) : DET_W'(det_q);

  always_comb begin
    logic [COF_W-1:0] cabs;
    front_d.sing = (det_q == '0);
    for (int i = 0; i < NUM_ELEM; i++) begin
      cabs = cof5_q[i][COF_W-1] ? COF_W'(-cof5_q[i]) : COF_W'(cof5_q[i]);
      front_d.lane[i].neg = cof5_q[i][COF_W-1] ^ det_neg;
      front_d.lane[i].num = (NUM_W'(cabs) << (2 * FRAC_W + 1)) + NUM_W'(det_abs);
      front_d.lane[i].den = NUM_W'(det_abs) << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

[design/symi_div_lane.sv]
// One lane of the pipelined restoring divider: one quotient bit per stage.
// The first stage only detects a quotient too large for the field; depends on symi_pkg.
module symi_div_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  symi_pkg::lane_t     lane_i,
  output symi_pkg::div_res_t  res_o
);
  import symi_pkg::*;

  logic [NUM_W-1:0] rem_q [DIV_LAT];
  logic [NUM_W-1:0] den_q [DIV_LAT];
  logic [QUO_W-1:0] quo_q [DIV_LAT];
  logic             ovf_q [DIV_LAT];
  logic             neg_q [DIV_LAT];

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    localparam int K = QUO_W - s;
    logic [NUM_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] quo_in;
    logic             ovf_in, neg_in;
    logic [CMP_W-1:0] rem_ext, den_ext;
    logic             ge;

    if (s == 0) begin : g_src_in
      assign rem_in = lane_i.num;
      assign den_in = lane_i.den;
      assign quo_in = '0;
      assign ovf_in = 1'b0;
      assign neg_in = lane_i.neg;
    end else begin : g_src_prev
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    assign rem_ext  = CMP_W'(rem_in);
    assign den_ext  = CMP_W'(den_in) << K;
    assign ge       = (rem_ext >= den_ext);

    if (s == 0) begin : g_range
      // quotient at or above 2^QUO_W always saturates
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_in;
          den_q[s] <= den_in;
          quo_q[s] <= quo_in;
          ovf_q[s] <= ovf_in | ge;
          neg_q[s] <= neg_in;
        end
      end
    end else begin : g_bit
      logic [CMP_W-1:0] diff_ext;

      assign diff_ext = rem_ext - den_ext;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? diff_ext[NUM_W-1:0] : rem_in;
          den_q[s] <= den_in;
          quo_q[s] <= quo_in | (ge ? (QUO_W'(1) << K) : '0);
          ovf_q[s] <= ovf_in;
          neg_q[s] <= neg_in;
        end
      end
    end
  end

  assign res_o.neg = neg_q[DIV_LAT-1];
  assign res_o.ovf = ovf_q[DIV_LAT-1];
  assign res_o.quo = quo_q[DIV_LAT-1];

endmodule

[design/symm3x3_inverse.sv]
// Top level of the symmetric 3x3 inverse: front end, six divider lanes, output skid.
// Depends on symi_pkg, symi_front and symi_div_lane.
//
//  port group  | dir | payload (lowest bits first)
//  s_axis      | in  | tdata: elem_xx, elem_yy, elem_zz, elem_yz, elem_xz, elem_xy
//  m_axis      | out | tdata: inv_xx .. inv_xy; tuser: singular, overflow
//
// One request enters per cycle while s_axis_tready is high; a result reaches m_axis after
// forty register stages: six in the front end, 33 divider stages (a range check, then one
// quotient bit each) and the output register.
// Reset clears only the valid bits and the output/skid flags.
// When the output stalls, one more result is taken into the skid register, then
// s_axis_tready falls and the whole pipeline holds until the skid register drains.
module symm3x3_inverse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // elem_xx, elem_yy, elem_zz, elem_yz, elem_xz, elem_xy
  input  logic [symi_pkg::TDATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // inv_xx, inv_yy, inv_zz, inv_yz, inv_xz, inv_xy
  output logic [symi_pkg::TDATA_W-1:0]  m_axis_tdata,
  // singular, overflow
  output logic [symi_pkg::TUSER_W-1:0]  m_axis_tuser
);
  import symi_pkg::*;

  logic                    en;
  elem_t [NUM_ELEM-1:0]    elem;
  front_t                  front;
  div_res_t                res [NUM_ELEM];
  logic [PIPE_LAT-1:0]     v_q;
  logic [DIV_LAT-1:0]      sing_q;
  logic                    push;
  logic [TDATA_W-1:0]      data_d;
  logic [TUSER_W-1:0]      user_d;
  logic                    out_v_q, skid_v_q;
  logic [TDATA_W-1:0]      out_data_q, skid_data_q;
  logic [TUSER_W-1:0]      out_user_q, skid_user_q;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_unpack
    assign elem[i] = s_axis_tdata[i*DATA_W +: DATA_W];
  end

  symi_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .elem_i  (elem),
    .front_o (front)
  );

  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
    symi_div_lane u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (front.lane[i]),
      .res_o  (res[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[DIV_LAT-2:0], front.sing};
    end
  end

  // Rounding is already in the quotient; here saturation, sign, zeroing of singular results and the flags.
  always_comb begin
    logic [QUO_W-1:0] lim, mag;
    logic             sat, any_sat;
    any_sat = 1'b0;
    data_d  = '0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      lim = res[i].neg ? LIM_NEG : LIM_POS;
      sat = res[i].ovf || (res[i].quo > lim);
      mag = sat ? lim : res[i].quo;
      if (!sing_q[DIV_LAT-1]) begin
        data_d[i*DATA_W +: DATA_W] = res[i].neg ? DATA_W'(-mag) : DATA_W'(mag);
      end
      any_sat = any_sat | sat;
    end
    user_d                = '0;
    user_d[USER_SINGULAR] = sing_q[DIV_LAT-1];
    user_d[USER_OVERFLOW] = any_sat && !sing_q[DIV_LAT-1];
  end

  assign push = en && v_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_data_q <= skid_v_q ? skid_data_q : data_d;
      out_user_q <= skid_v_q ? skid_user_q : user_d;
    end else if (push) begin
      skid_data_q <= data_d;
      skid_user_q <= user_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_user_q[USER_SINGULAR]) |->
      (out_data_q == '0 && !out_user_q[USER_OVERFLOW]))
    else $error("singular result carries data or overflow");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_v_q && !m_axis_tready) |=> skid_v_q)
    else $error("stalled result was not caught by the skid register");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_v_q && !m_axis_tready) |=> (skid_v_q && $stable(v_q)))
    else $error("pipeline moved while the skid register was full");

endmodule
